### hdl/oaat_pkg.sv
`default_nettype none

package oaat_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PC_W = 3;
  localparam int unsigned CNT_W = 5;
  localparam logic [HASH_W-1:0] TABLE_SIZE_RESET = 32'd1024;

  // datapath operation selected by the control word
  typedef enum logic [2:0] {
    OP_ACCEPT   = 3'd0,
    OP_MIX3     = 3'd1,
    OP_MIX11    = 3'd2,
    OP_MIX15    = 3'd3,
    OP_DIV_INIT = 3'd4,
    OP_DIV_STEP = 3'd5,
    OP_EMIT     = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  // jump condition; taken goes to target, otherwise fall through to pc + 1
  typedef enum logic [1:0] {
    JC_NEVER       = 2'd0,
    JC_NO_KEY_END  = 2'd1,
    JC_CNT_NZ      = 2'd2,
    JC_OUT_BUSY    = 2'd3
  } cond_t;

  localparam logic [PC_W-1:0] PC_START  = 3'd0;
  localparam logic [PC_W-1:0] PC_DIV    = 3'd5;
  localparam logic [PC_W-1:0] PC_EMIT   = 3'd6;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic            jump_always;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic key_end;
    logic cnt_nz;
    logic out_busy;
  } status_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      3'd0:    w = '{OP_ACCEPT,   JC_NO_KEY_END, 1'b0, PC_START};
      3'd1:    w = '{OP_MIX3,     JC_NEVER,      1'b0, PC_START};
      3'd2:    w = '{OP_MIX11,    JC_NEVER,      1'b0, PC_START};
      3'd3:    w = '{OP_MIX15,    JC_NEVER,      1'b0, PC_START};
      3'd4:    w = '{OP_DIV_INIT, JC_NEVER,      1'b0, PC_START};
      3'd5:    w = '{OP_DIV_STEP, JC_CNT_NZ,     1'b0, PC_DIV};
      3'd6:    w = '{OP_EMIT,     JC_OUT_BUSY,   1'b0, PC_EMIT};
      default: w = '{OP_NOP,      JC_NEVER,      1'b1, PC_START};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### hdl/oaat_seq.sv
`default_nettype none

module oaat_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire oaat_pkg::status_t status,
  output oaat_pkg::ctrl_t       ctrl
);

  logic [oaat_pkg::PC_W-1:0] pc_r;
  logic [oaat_pkg::PC_W-1:0] pc_nxt;
  oaat_pkg::uword_t          uw;
  logic                      taken;

  assign uw = oaat_pkg::ucode(pc_r);
  assign ctrl.op = uw.op;

  always_comb begin
    case (uw.cond)
      oaat_pkg::JC_NO_KEY_END: taken = !status.key_end;
      oaat_pkg::JC_CNT_NZ:     taken = status.cnt_nz;
      oaat_pkg::JC_OUT_BUSY:   taken = status.out_busy;
      default:                 taken = 1'b0;
    endcase
    if (taken || uw.jump_always) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= oaat_pkg::PC_START;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/oaat_dp.sv
`default_nettype none

module oaat_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire oaat_pkg::ctrl_t             ctrl,
  output oaat_pkg::status_t                status,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [oaat_pkg::BYTE_W-1:0] in_key_byte,
  input  wire logic                        in_is_last,
  input  wire logic                        in_is_empty,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [oaat_pkg::HASH_W-1:0]      out_bucket_index,
  output logic [oaat_pkg::HASH_W-1:0]      out_hash_value,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [oaat_pkg::HASH_W-1:0] cfg_data
);

  localparam int unsigned W = oaat_pkg::HASH_W;

  logic [W-1:0]                 hash_r, hash_nxt;
  logic [W-1:0]                 dvd_r, dvd_nxt;
  logic [W-1:0]                 rem_r, rem_nxt;
  logic [oaat_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]                 tsize_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [W-1:0]                 out_bucket_r, out_hash_r;
  logic                         in_take;
  logic                         emit_go;
  logic [W:0]                   rem_sh;
  logic [W:0]                   rem_sub;
  logic [W-1:0]                 absorbed;
  logic [W-1:0]                 sum_b;

  assign in_stall  = (ctrl.op != oaat_pkg::OP_ACCEPT);
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign status.key_end  = in_take && (in_is_last || in_is_empty);
  assign status.cnt_nz   = (cnt_r != '0);
  assign status.out_busy = out_valid_r && out_stall;

  assign emit_go = (ctrl.op == oaat_pkg::OP_EMIT) && !status.out_busy;

  assign out_valid        = out_valid_r;
  assign out_bucket_index = out_bucket_r;
  assign out_hash_value   = out_hash_r;

  // absorb one key byte into the running hash
  assign sum_b    = hash_r + {{(W-oaat_pkg::BYTE_W){1'b0}}, in_key_byte};
  assign absorbed = (sum_b + (sum_b << 10)) ^ ((sum_b + (sum_b << 10)) >> 6);

  // restoring divide, one quotient bit per step
  assign rem_sh  = {rem_r, dvd_r[W-1]};
  assign rem_sub = rem_sh - {1'b0, tsize_r};

  always_comb begin
    hash_nxt = hash_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    case (ctrl.op)
      oaat_pkg::OP_ACCEPT: begin
        if (in_take) begin
          hash_nxt = in_is_empty ? '0 : absorbed;
        end
      end
      oaat_pkg::OP_MIX3:  hash_nxt = hash_r + (hash_r << 3);
      oaat_pkg::OP_MIX11: hash_nxt = hash_r ^ (hash_r >> 11);
      oaat_pkg::OP_MIX15: hash_nxt = hash_r + (hash_r << 15);
      oaat_pkg::OP_DIV_INIT: begin
        dvd_nxt = hash_r;
        rem_nxt = '0;
        cnt_nxt = oaat_pkg::CNT_W'(W - 1);
      end
      oaat_pkg::OP_DIV_STEP: begin
        rem_nxt = (rem_sh >= {1'b0, tsize_r}) ? rem_sub[W-1:0] : rem_sh[W-1:0];
        dvd_nxt = {dvd_r[W-2:0], 1'b0};
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      oaat_pkg::OP_EMIT: begin
        if (emit_go) begin
          hash_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= '0;
      tsize_r     <= oaat_pkg::TABLE_SIZE_RESET;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        tsize_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (emit_go) begin
      out_hash_r   <= hash_r;
      // no buckets: report index zero
      out_bucket_r <= (tsize_r == '0) ? '0 : rem_r;
    end
  end

  a_busy_after_key_end: assert property (@(posedge clk) disable iff (!rst_n)
    status.key_end |=> in_stall)
    else $error("input taken right after key end");

  a_bucket_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (tsize_r != '0) |-> (out_bucket_r < tsize_r))
    else $error("bucket index not below table size");

  a_div_done_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == oaat_pkg::OP_EMIT) |-> (cnt_r == '0))
    else $error("emit before divide finished");

  a_hash_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (hash_r == '0))
    else $error("running hash not cleared after result");

endmodule

`default_nettype wire

### hdl/one_at_a_time_hash_bucket.sv
// Key bytes are taken one per cycle while in_stall is low; each byte is absorbed in the
// cycle it is accepted. A key's last byte (or an empty key) runs the final mix and a
// 32-step bit-serial modulo from the control program; the emit step then registers the
// result and holds while the output is stalled. No byte is accepted until that is done.
// Synchronous active-low reset clears the running hash and step counter, drops
// out_valid and loads table_size with 1024.
`default_nettype none

module one_at_a_time_hash_bucket (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [oaat_pkg::BYTE_W-1:0] in_key_byte,
  input  wire logic                        in_is_last,
  input  wire logic                        in_is_empty,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [oaat_pkg::HASH_W-1:0]      out_bucket_index,
  output logic [oaat_pkg::HASH_W-1:0]      out_hash_value,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [oaat_pkg::HASH_W-1:0] cfg_data
);

  oaat_pkg::ctrl_t   ctrl;
  oaat_pkg::status_t status;

  oaat_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  oaat_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .status           (status),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_byte      (in_key_byte),
    .in_is_last       (in_is_last),
    .in_is_empty      (in_is_empty),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_bucket_index (out_bucket_index),
    .out_hash_value   (out_hash_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

endmodule

`default_nettype wire
